FILE: hdl/icf_pkg.sv
// Shared types, register codes and kernel weights for the image convolution filter.
// No dependencies; imported by icf_window, icf_kernel, image_convolution_filter and tb_top.
package icf_pkg;

  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_WINDOW_DEF = 7;
  localparam int MAX_HEIGHT     = 4096;
  localparam int PIX_W          = 8;
  localparam int ROW_W          = 12;
  localparam int HGT_W          = 13;
  localparam int CNT_W          = 22;
  localparam int WT_W           = 12;
  localparam int SUM_W          = 24;

  // configuration register indexes
  localparam logic [1:0] REG_KIND   = 2'd0;
  localparam logic [1:0] REG_WSIZE  = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // filter families
  localparam logic [1:0] KIND_EDGE    = 2'd0;
  localparam logic [1:0] KIND_SHARPEN = 2'd1;
  localparam logic [1:0] KIND_BLUR    = 2'd2;

  localparam int BINOM [3][7] = '{
    '{1, 2, 1, 0, 0, 0, 0},
    '{1, 4, 6, 4, 1, 0, 0},
    '{1, 6, 15, 20, 15, 6, 1}
  };

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [1:0] kind;     // already clamped to a valid family
    logic [1:0] radius;   // 1..3
  } kcfg_t;

  typedef struct packed {
    logic             last;
    logic [ROW_W-1:0] row;
  } actl_t;

  // Weight of window tap (k, j): k rows and j columns back from the newest pixel.
  function automatic logic signed [WT_W-1:0] tap_wt(logic [1:0] kind, logic [1:0] r,
                                                     int k, int j);
    int dy;
    int dx;
    int n;
    int w;
    dy = int'(r) - k;
    dx = int'(r) - j;
    n  = 2 * int'(r) + 1;
    w  = 0;
    if (dy >= -int'(r) && dy <= int'(r) && dx >= -int'(r) && dx <= int'(r)) begin
      if (kind == KIND_EDGE) begin
        if (r == 2'd1) begin
          if (dy == 0 && dx == 0) w = 4;
          else if ((dy == 0) != (dx == 0)) w = -1;
        end else begin
          w = (dy == 0 && dx == 0) ? n * n - 1 : -1;
        end
      end else if (kind == KIND_SHARPEN) begin
        w = (dy == 0 && dx == 0) ? n * n : -1;
      end else begin
        w = BINOM[int'(r) - 1][k] * BINOM[int'(r) - 1][j];
      end
    end
    return WT_W'(w);
  endfunction

endpackage

FILE: hdl/icf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module icf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: hdl/icf_window.sv
// Line delay memory and NxN window register array.
// Depends on icf_pkg and icf_ram.
module icf_window import icf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          adv,
  input  pix_t          pix,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] raddr,
  output pix_t          win [MAX_WINDOW][MAX_WINDOW]
);

  localparam int LINES = MAX_WINDOW - 1;
  localparam int LW    = LINES * PIX_W;

  logic [LW-1:0] rd_data;
  logic [LW-1:0] wword_r;
  logic          fwd_r;
  logic [LW-1:0] older;
  logic [LW-1:0] wword;
  pix_t          colv [MAX_WINDOW];

  // older[k] = pixel k+1 rows back in the same column
  assign older = fwd_r ? wword_r : rd_data;

  always_comb begin
    colv[0] = pix;
    for (int k = 1; k < MAX_WINDOW; k++) colv[k] = older[(k-1)*PIX_W +: PIX_W];
    for (int k = 0; k < LINES; k++) wword[k*PIX_W +: PIX_W] = colv[k];
  end

  icf_ram #(.WIDTH(LW), .DEPTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .we    (adv),
    .waddr (waddr),
    .wdata (wword),
    .re    (adv),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // one-pixel rows read back what is written in the same cycle
  always_ff @(posedge clk) begin
    if (adv) begin
      wword_r <= wword;
      fwd_r   <= (raddr == waddr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        win[k][0] <= colv[k];
        for (int j = 1; j < MAX_WINDOW; j++) win[k][j] <= win[k][j-1];
      end
    end
  end

endmodule

FILE: hdl/icf_kernel.sv
// Masked weighted row sums, final sum, rectify/shift/clamp into the output register.
// Depends on icf_pkg.
module icf_kernel import icf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1)
) (
  input  logic          clk,
  input  logic          en,
  input  kcfg_t         kcfg,
  input  logic [WW-1:0] weff,
  input  logic [HGT_W-1:0] heff,
  input  actl_t         actl,
  input  logic [CW-1:0] col,
  input  pix_t          win [MAX_WINDOW][MAX_WINDOW],
  output pix_t          pix_out,
  output logic          last_out
);

  logic [MAX_WINDOW-1:0]   rmask;
  logic [MAX_WINDOW-1:0]   cmask;
  logic signed [SUM_W-1:0] rs_nxt [MAX_WINDOW];
  logic signed [SUM_W-1:0] rs_r   [MAX_WINDOW];
  logic                    last_b_r;
  logic signed [SUM_W-1:0] tot;
  pix_t                    res;

  always_comb begin
    int rr;
    int cc;
    logic signed [SUM_W-1:0] acc;
    for (int k = 0; k < MAX_WINDOW; k++) begin
      rr = int'(actl.row) + int'(kcfg.radius) - k;
      rmask[k] = (rr >= 0) && (rr < int'(heff));
    end
    for (int j = 0; j < MAX_WINDOW; j++) begin
      cc = int'(col) + int'(kcfg.radius) - j;
      cmask[j] = (cc >= 0) && (cc < int'(weff));
    end
    for (int k = 0; k < MAX_WINDOW; k++) begin
      acc = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if (rmask[k] && cmask[j])
          acc = acc + SUM_W'($signed({1'b0, win[k][j]})) *
                      SUM_W'(tap_wt(kcfg.kind, kcfg.radius, k, j));
      end
      rs_nxt[k] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_r     <= rs_nxt;
      last_b_r <= actl.last;
    end
  end

  always_comb begin
    tot = '0;
    for (int k = 0; k < MAX_WINDOW; k++) tot = tot + rs_r[k];
    if (kcfg.kind == KIND_EDGE && tot < 0) tot = -tot;
    if (kcfg.kind == KIND_BLUR) tot = tot >>> {kcfg.radius, 2'b00};
    if (tot < 0) res = '0;
    else if (tot > SUM_W'(255)) res = 8'hFF;
    else res = tot[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pix_out  <= res;
      last_out <= last_b_r;
    end
  end

endmodule

FILE: hdl/image_convolution_filter.sv
// Streaming 2D convolution filter: edge, sharpen or binomial blur over a 3x3..7x7 window.
// Depends on icf_pkg, icf_window, icf_kernel (and icf_ram below it).
//
// Usage: pixels enter on in_* in raster order, one per transaction (in_tdata = pixel,
// in_tuser = filler flag). A result leaves on out_* for every image position once
// r*width + r items of the frame are in (r = window radius); send that many filler items
// after the last pixel to flush the frame. out_tlast marks the last position of a frame.
// out_tvalid rises once its input transaction has passed the window register, row-sum
// register and output register. Throughput: one item per clock unless stalled,
// set by the single line-memory port pair, written and read once per transaction.
// Configure through cfg_we/cfg_index/cfg_wdata between frames with the block drained.
// Reset: registers go to edge detect, 3x3, 512x512; counters clear; line memory is not
// cleared, pixels outside the image are masked to zero instead.
// Receiver stall: the whole pipeline holds while out_tvalid is high and out_tready low;
// in_tready then drops in the same cycle, so nothing is lost.
module image_convolution_filter import icf_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] pixel_in
  input  logic        in_tuser,    // [0] is_filler
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [7:0] pixel_out
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_wdata
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int LAG_W  = WW + 3;
  localparam int AREA_W = WW + HGT_W;
  localparam int RMAX   = MAX_WINDOW / 2;

  logic [1:0]       kind_r, wsize_r;
  logic [9:0]       width_r;
  logic [HGT_W-1:0] height_r;

  logic [WW-1:0]     weff;
  logic [HGT_W-1:0]  heff;
  logic [1:0]        radius;
  kcfg_t             kcfg;
  logic [LAG_W-1:0]  lag;
  logic [AREA_W-1:0] area;

  logic [CNT_W-1:0] t_r;
  logic [CW-1:0]    col_r, p_r, pw, pn;
  logic [ROW_W-1:0] row_r;
  logic             en, acc, produce, last;
  pix_t             pix;

  logic             a_valid_r, b_valid_r, out_valid_r;
  actl_t            actl_r;
  logic [CW-1:0]    acol_r;
  pix_t             win [MAX_WINDOW][MAX_WINDOW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= KIND_EDGE;
      wsize_r  <= 2'd0;
      width_r  <= 10'd512;
      height_r <= 13'd512;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KIND:   kind_r   <= cfg_wdata[1:0];
        REG_WSIZE:  wsize_r  <= cfg_wdata[1:0];
        REG_WIDTH:  width_r  <= cfg_wdata[9:0];
        REG_HEIGHT: height_r <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (width_r == '0) weff = WW'(1);
    else if (32'(width_r) > MAX_WIDTH) weff = WW'(MAX_WIDTH);
    else weff = WW'(width_r);
    if (height_r == '0) heff = HGT_W'(1);
    else if (32'(height_r) > MAX_HEIGHT) heff = HGT_W'(MAX_HEIGHT);
    else heff = height_r;
    radius = (wsize_r > 2'd2) ? 2'd3 : wsize_r + 2'd1;
    if (32'(radius) > RMAX) radius = 2'(RMAX);
    kcfg.kind   = (kind_r > KIND_BLUR) ? KIND_BLUR : kind_r;
    kcfg.radius = radius;
  end

  // frame geometry follows the registers at once
  assign lag  = LAG_W'(radius) * LAG_W'(weff) + LAG_W'(radius);
  assign area = AREA_W'(weff) * AREA_W'(heff);

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;
  assign produce   = 32'(t_r) >= 32'(lag);
  assign last      = (32'(row_r) >= 32'(heff) - 1) && (32'(col_r) >= 32'(weff) - 1);
  assign pix       = (!in_tuser && 32'(t_r) < 32'(area)) ? in_tdata : '0;
  // a pointer left past a narrower row restarts at zero
  assign pw        = (32'(p_r) >= 32'(weff)) ? '0 : p_r;
  assign pn        = (32'(pw) + 1 >= 32'(weff)) ? '0 : pw + CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r   <= '0;
      col_r <= '0;
      row_r <= '0;
      p_r   <= '0;
    end else if (acc) begin
      p_r <= pn;
      if (produce && last) begin
        t_r   <= '0;
        col_r <= '0;
        row_r <= '0;
      end else begin
        if (t_r != '1) t_r <= t_r + CNT_W'(1);
        if (produce) begin
          if (32'(col_r) + 1 >= 32'(weff)) begin
            col_r <= '0;
            row_r <= row_r + ROW_W'(1);
          end else begin
            col_r <= col_r + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r   <= acc && produce;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      actl_r.last <= last;
      actl_r.row  <= row_r;
      acol_r      <= col_r;
    end
  end

  icf_window #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_window (
    .clk   (clk),
    .adv   (acc),
    .pix   (pix),
    .waddr (pw),
    .raddr (pn),
    .win   (win)
  );

  icf_kernel #(.MAX_WIDTH(MAX_WIDTH), .MAX_WINDOW(MAX_WINDOW)) u_kernel (
    .clk      (clk),
    .en       (en),
    .kcfg     (kcfg),
    .weff     (weff),
    .heff     (heff),
    .actl     (actl_r),
    .col      (acol_r),
    .win      (win),
    .pix_out  (out_tdata),
    .last_out (out_tlast)
  );

  assign out_tvalid = out_valid_r;

  a_b_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    en && b_valid_r |=> out_valid_r)
    else $error("row-sum stage result lost");

  a_cnt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(t_r) && $stable(col_r) && $stable(row_r))
    else $error("position counters moved while stalled");

  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !produce |=> !a_valid_r)
    else $error("result started inside the start-up lag");

  a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !acc |=> $stable(p_r))
    else $error("line pointer moved without a transaction");

endmodule

FILE: bench/tb_top.sv
// Testbench for image_convolution_filter: raster frames against an in-bench predictor.
// Depends on icf_pkg (register and filter codes) and the image_convolution_filter RTL.
module tb_top;
  import icf_pkg::*;

  localparam int HIST_D   = 6 * 512 + 7;
  localparam int WDOG_MAX = 3000;
  localparam int LONG_HOLD = 400;
  // window codes and the out-of-range codes of both selectors
  localparam logic [1:0] WIN3      = 2'd0;
  localparam logic [1:0] WIN5      = 2'd1;
  localparam logic [1:0] WIN7      = 2'd2;
  localparam logic [1:0] WIN_OVER  = 2'd3;
  localparam logic [1:0] KIND_OVER = 2'd3;

  typedef struct {
    logic [7:0] pix;
    logic       last;
  } conv_result_t;

  class conv_scoreboard;
    logic [7:0]   hist [HIST_D];
    int           wp;
    int           taken;
    int           col;
    int           row;
    logic [1:0]   kind;
    logic [1:0]   wsel;
    int           width;
    int           height;
    int           errors;
    conv_result_t pending_q [$];

    function new();
      foreach (hist[i]) hist[i] = '0;
      wp = 0; taken = 0; col = 0; row = 0;
      kind = KIND_EDGE; wsel = WIN3; width = 512; height = 512; errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        REG_KIND:   kind = val[1:0];
        REG_WSIZE:  wsel = val[1:0];
        REG_WIDTH:  width = int'(val[9:0]);
        default:    height = int'(val);
      endcase
    endfunction

    function int eff_w();
      return width < 1 ? 1 : (width > 512 ? 512 : width);
    endfunction
    function int eff_h();
      return height < 1 ? 1 : (height > 4096 ? 4096 : height);
    endfunction
    function int radius();
      return wsel > WIN7 ? 3 : int'(wsel) + 1;
    endfunction
    function int lag();
      return radius() * eff_w() + radius();
    endfunction

    function int weight(logic [1:0] k, int r, int dy, int dx);
      int n;
      int b [3][7];
      n = 2 * r + 1;
      b = '{'{1, 2, 1, 0, 0, 0, 0}, '{1, 4, 6, 4, 1, 0, 0}, '{1, 6, 15, 20, 15, 6, 1}};
      if (k == KIND_EDGE) begin
        if (r == 1) begin
          if (dy == 0 && dx == 0) return 4;
          return ((dy == 0) != (dx == 0)) ? -1 : 0;
        end
        return (dy == 0 && dx == 0) ? n * n - 1 : -1;
      end
      if (k == KIND_SHARPEN) return (dy == 0 && dx == 0) ? n * n : -1;
      return b[r-1][dy+r] * b[r-1][dx+r];
    endfunction

    // accepted input transaction: update history, maybe predict one pixel
    function void note_pixel(logic [7:0] pix, logic filler);
      int w, h, r, t, newest, lg, sum, rr, cc, wt, idx;
      logic [1:0] k;
      conv_result_t res;
      w = eff_w(); h = eff_h(); r = radius(); lg = lag();
      k = kind == KIND_OVER ? KIND_BLUR : kind;
      t = taken;
      newest = wp;
      hist[newest] = (!filler && t < w * h) ? pix : 8'd0;
      wp = (wp + 1) % HIST_D;
      if (taken < 22'h3FFFFF) taken++;
      if (t < lg) return;
      sum = 0;
      for (int dy = -r; dy <= r; dy++) begin
        rr = row + dy;
        for (int dx = -r; dx <= r; dx++) begin
          cc = col + dx;
          wt = weight(k, r, dy, dx);
          if (rr < 0 || rr >= h || cc < 0 || cc >= w || wt == 0) continue;
          idx = (newest + HIST_D - (lg - (dy * w + dx))) % HIST_D;
          sum += int'(hist[idx]) * wt;
        end
      end
      if (k == KIND_EDGE && sum < 0) sum = -sum;
      if (k == KIND_BLUR) sum = sum >>> (4 * r);
      res.pix = sum < 0 ? 8'd0 : (sum > 255 ? 8'd255 : 8'(sum));
      res.last = row >= h - 1 && col >= w - 1;
      pending_q.push_back(res);
      if (res.last) begin
        taken = 0; col = 0; row = 0;
      end else if (col + 1 >= w) begin
        col = 0; row++;
      end else begin
        col++;
      end
    endfunction

    function void check_pixel(logic [7:0] pix, logic last);
      conv_result_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result pixel_out=%0d frame_last=%0d", pix, last);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (pix !== e.pix) begin
        $error("pixel_out expected %0d actual %0d", e.pix, pix);
        errors++;
      end
      if (last !== e.last) begin
        $error("frame_last expected %0d actual %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [12:0] cfg_wdata = '0;

  conv_scoreboard sb = new();
  int  idle_mode = 0;   // 0 none, 1 sender 81%, 2 receiver 81%, 3 both 6%
  bit  hold_req = 0;
  int  quiet_cycles = 0;

  always #5 clk = ~clk;

  image_convolution_filter DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // receiver: random stalls per mode, plus a counted long hold on request
  always @(negedge clk) begin
    static int hold_left = 0;
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else if (idle_mode == 2) out_tready = $urandom_range(0, 99) >= 81;
    else if (idle_mode == 3) out_tready = $urandom_range(0, 99) >= 6;
    else out_tready = 1'b1;
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) sb.check_pixel(out_tdata, out_tlast);
    if ((out_tvalid && out_tready) || (in_tvalid && in_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_pixel(logic [7:0] pix, logic filler);
    int pct;
    pct = idle_mode == 1 ? 81 : (idle_mode == 3 ? 6 : 0);
    while ($urandom_range(0, 99) < pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = pix;
    in_tuser = filler;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(pix, filler);
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [12:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_all(logic [1:0] k, logic [1:0] ws, int w, int h);
    write_cfg(REG_KIND, 13'(k));
    write_cfg(REG_WSIZE, 13'(ws));
    write_cfg(REG_WIDTH, 13'(w));
    write_cfg(REG_HEIGHT, 13'(h));
  endtask

  // one frame: pixels (sometimes with fillers inside), then flush items, maybe cut short
  task automatic run_frame(int pix_mode, bit broken);
    int n, nflush;
    logic [7:0] p;
    n = sb.eff_w() * sb.eff_h();
    for (int i = 0; i < n; i++) begin
      case (pix_mode)
        0: p = 8'($urandom_range(0, 255));
        1: p = (i % 2) ? 8'd255 : 8'd0;
        2: p = 8'd255;
        default: p = $urandom_range(0, 3) == 0 ? 8'd255 : 8'($urandom_range(0, 255));
      endcase
      send_pixel(p, pix_mode == 3 && $urandom_range(0, 7) == 0);
    end
    nflush = sb.lag();
    if (broken) nflush = $urandom_range(0, nflush);
    for (int i = 0; i < nflush; i++)
      send_pixel(8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0);
  endtask

  // finish any open frame, then wait until the block is empty
  task automatic end_phase();
    while (sb.taken != 0) send_pixel(8'($urandom_range(0, 255)), 1'b1);
    in_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: borders, clamping at both ends, fillers inside, odd register values
    set_all(KIND_EDGE, WIN3, 4, 3);
    run_frame(1, 0);
    end_phase();
    write_cfg(REG_KIND, 13'(KIND_SHARPEN));
    run_frame(2, 0);
    end_phase();
    set_all(KIND_OVER, WIN_OVER, 0, 0);
    run_frame(3, 0);
    end_phase();
    set_all(KIND_BLUR, WIN7, 3, 2);
    run_frame(3, 0);
    end_phase();

    // extremes of width and height
    idle_mode = 3;
    set_all(KIND_SHARPEN, WIN3, 1023, 1);
    hold_req = 1;
    run_frame(0, 0);
    end_phase();
    idle_mode = 0;
    set_all(KIND_EDGE, WIN3, 1, 100);
    run_frame(3, 0);
    end_phase();

    // random phases over every filter and window code
    for (int ph = 0; ph < 16; ph++) begin
      idle_mode = ph % 4;
      set_all(2'(ph / 4), 2'(ph % 4), $urandom_range(1, 6), $urandom_range(1, 4));
      for (int f = 0; f < 2; f++) run_frame($urandom_range(0, 3), $urandom_range(0, 9) == 0);
      end_phase();
    end

    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: files.f
hdl/icf_pkg.sv
hdl/icf_ram.sv
hdl/icf_window.sv
hdl/icf_kernel.sv
hdl/image_convolution_filter.sv
bench/tb_top.sv
